FILE: rtl/terminal_text_line_ring_defines.svh
// assertion macros for the terminal line ring
// used by the top level only; no other dependencies
`ifndef TERMINAL_TEXT_LINE_RING_DEFINES_SVH
`define TERMINAL_TEXT_LINE_RING_DEFINES_SVH

// same-cycle implication, reset masks the check
`define TRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define TRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/trl_pkg.sv
// shared constants, codes and types of the terminal line ring
// no dependencies
`default_nettype none

package trl_pkg;

	localparam int LINE_COLUMNS = 32;
	localparam int SCREEN_ROWS  = 8;
	localparam int RING_LINES   = 16;

	localparam int CHAR_W   = 7;
	localparam int BYTE_W   = 8;
	localparam int ROW_W    = 3;
	localparam int COL_W    = $clog2(LINE_COLUMNS);
	localparam int CUR_W    = COL_W + 1;
	localparam int LINE_W   = $clog2(RING_LINES);
	localparam int ROW_BITS = LINE_COLUMNS * CHAR_W;
	localparam int SUM_W    = $clog2(2 * RING_LINES + SCREEN_ROWS) + 1;

	localparam int TAB_STEP  = 8;
	localparam int TAB_SHIFT = $clog2(TAB_STEP);

	// oldest shown line sits this far past the head, modulo the ring
	localparam int ROW_OFFSET = RING_LINES - (SCREEN_ROWS % RING_LINES);

	localparam logic [BYTE_W-1:0] CH_ESC    = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
	localparam logic [BYTE_W-1:0] CH_DEL    = 8'd127;

	localparam logic [CHAR_W-1:0]   SPACE_CHAR = 7'd32;
	localparam logic [ROW_BITS-1:0] SPACE_ROW  = {LINE_COLUMNS{SPACE_CHAR}};
	localparam logic [COL_W-1:0]    LAST_COL   = COL_W'(LINE_COLUMNS - 1);

	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_LOAD  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	typedef struct packed {
		logic busy;
		logic mem_we;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/trl_in_if.sv
// request channel: command, byte to feed, screen row to read
// depends on trl_pkg
`default_nettype none

interface trl_in_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [trl_pkg::BYTE_W-1:0] data_byte;
	logic [trl_pkg::ROW_W-1:0]  screen_row;

	modport source (output valid, command, data_byte, screen_row, input ready);
	modport sink (input valid, command, data_byte, screen_row, output ready);
endinterface

`default_nettype wire

FILE: rtl/trl_out_if.sv
// result channel: one character word per column of a row
// depends on trl_pkg
`default_nettype none

interface trl_out_if;
	logic                       valid;
	logic                       ready;
	logic [trl_pkg::CHAR_W-1:0] character;
	logic [trl_pkg::COL_W-1:0]  column;
	logic                       last;

	modport source (output valid, character, column, last, input ready);
	modport sink (input valid, character, column, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/terminal_text_line_ring.sv
// channel   dir  payload                          accepted when
// request   in   command, data_byte, screen_row   valid && ready
// result    out  character, column, last          valid && ready
//
// printable byte: row fetch on the read port, then merged write-back on the write port; others: decoded on acceptance
// a row read fetches the row and scans it in LOAD, then takes one cycle per column in EMIT
// for all 32 columns, longer while result is stalled
// reset needs no clearing pass: one valid bit per ring line makes an unwritten line
// read as spaces, and a newline blanks a line by clearing its bit
// a pending result word stays in the output register while request is open again
// depends on trl_pkg, trl_in_if, trl_out_if, trl_line_ram, trl_ctrl and the defines header
`default_nettype none

`include "terminal_text_line_ring_defines.svh"

module terminal_text_line_ring (
	input  wire logic clk,
	input  wire logic arst_n,
	trl_in_if.sink    request,
	trl_out_if.source result
);

	logic                           mem_we;
	logic [trl_pkg::LINE_W-1:0]     mem_waddr;
	logic [trl_pkg::ROW_BITS-1:0]   mem_wdata;
	logic                           mem_re;
	logic [trl_pkg::LINE_W-1:0]     mem_raddr;
	logic [trl_pkg::ROW_BITS-1:0]   mem_rdata;
	trl_pkg::status_t               status;

	logic                           req_fire;
	logic                           read_fire;
	logic                           last_word;
	logic                           last_ok;

	trl_line_ram #(
		.DEPTH(trl_pkg::RING_LINES),
		.WIDTH(trl_pkg::ROW_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	trl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.status    (status)
	);

	assign req_fire  = request.valid && request.ready;
	assign read_fire = req_fire && (request.command == trl_pkg::CMD_READ);
	assign last_word = result.valid && result.last;
	assign last_ok   = (result.column == trl_pkg::LAST_COL);

	// a row read keeps the request side closed while it walks the columns
	`TRL_ASSERT_NEXT(a_read_holds, clk, arst_n, read_fire, status.busy, "open after a read")
	// the write-back always comes in the cycle after an accepted word
	`TRL_ASSERT_IMP(a_wb_after_accept, clk, arst_n, status.mem_we, $past(req_fire), "stray write")
	// last word of a row sits on the final column
	`TRL_ASSERT_IMP(a_last_column, clk, arst_n, last_word, last_ok, "last flag off the final column")

endmodule

`default_nettype wire

FILE: rtl/trl_line_ram.sv
// generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module trl_line_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 224
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/trl_ctrl.sv
// byte decoder, cursor and escape state, row read-modify-write and row readout
// depends on trl_pkg, trl_in_if, trl_out_if; drives trl_line_ram ports
`default_nettype none

module trl_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	trl_in_if.sink                                   request,
	trl_out_if.source                                result,
	output logic                                     mem_we,
	output logic      [trl_pkg::LINE_W-1:0]          mem_waddr,
	output logic      [trl_pkg::ROW_BITS-1:0]        mem_wdata,
	output logic                                     mem_re,
	output logic      [trl_pkg::LINE_W-1:0]          mem_raddr,
	input  wire logic [trl_pkg::ROW_BITS-1:0]        mem_rdata,
	output trl_pkg::status_t                         status
);

	logic [1:0]                          state_q;
	logic [trl_pkg::LINE_W-1:0]          head_q;
	logic [trl_pkg::CUR_W-1:0]           cursor_q;
	logic                                esc_q;
	logic                                brk_q;
	logic [trl_pkg::RING_LINES-1:0]      row_valid_q;

	logic [trl_pkg::LINE_W-1:0]          wl_q;
	logic [trl_pkg::COL_W-1:0]           wcol_q;
	logic [trl_pkg::CHAR_W-1:0]          wchar_q;
	logic [trl_pkg::LINE_W-1:0]          rline_q;
	logic [trl_pkg::ROW_BITS-1:0]        row_q;
	logic [trl_pkg::LINE_COLUMNS-1:0]    mask_q;
	logic [trl_pkg::COL_W-1:0]           rcol_q;

	logic                                out_valid_q;
	logic [trl_pkg::CHAR_W-1:0]          out_char_q;
	logic [trl_pkg::COL_W-1:0]           out_col_q;
	logic                                out_last_q;

	logic                                accept;
	logic [trl_pkg::BYTE_W-1:0]          b;
	logic                                is_letter;
	logic                                is_print;
	logic                                full;
	logic [trl_pkg::LINE_W-1:0]          head_inc;
	logic [trl_pkg::LINE_W-1:0]          head_dec;
	logic [trl_pkg::CUR_W:0]             tab_next;
	logic [trl_pkg::SUM_W-1:0]           line_sum;
	logic [trl_pkg::LINE_W-1:0]          rline;
	logic                                row_ok;

	logic [trl_pkg::LINE_W-1:0]          head_d;
	logic [trl_pkg::CUR_W-1:0]           cursor_d;
	logic                                esc_d;
	logic                                brk_d;
	logic                                clear_en;
	logic                                start_wr;
	logic                                start_rd;
	logic [trl_pkg::LINE_W-1:0]          wl_d;
	logic [trl_pkg::COL_W-1:0]           wcol_d;

	logic [trl_pkg::ROW_BITS-1:0]        load_row;
	logic [trl_pkg::LINE_COLUMNS-1:0]    load_mask;
	logic                                keep;
	logic                                slot_free;

	assign accept    = request.valid && request.ready;
	assign b         = request.data_byte;
	assign is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	assign is_print  = (b >= trl_pkg::CH_SPACE) && (b < trl_pkg::CH_DEL);
	assign full      = cursor_q >= trl_pkg::CUR_W'(trl_pkg::LINE_COLUMNS);
	assign head_inc  = (head_q == trl_pkg::LINE_W'(trl_pkg::RING_LINES - 1)) ?
		'0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ?
		trl_pkg::LINE_W'(trl_pkg::RING_LINES - 1) : head_q - 1'b1;
	assign tab_next  = {1'b0, cursor_q[trl_pkg::CUR_W-1:trl_pkg::TAB_SHIFT],
		trl_pkg::TAB_SHIFT'(0)} + (trl_pkg::CUR_W+1)'(trl_pkg::TAB_STEP);

	assign line_sum = trl_pkg::SUM_W'(head_q) + trl_pkg::SUM_W'(request.screen_row)
		+ trl_pkg::SUM_W'(trl_pkg::ROW_OFFSET);
	assign rline    = trl_pkg::LINE_W'(line_sum % trl_pkg::RING_LINES);
	assign row_ok   = {1'b0, request.screen_row} < (trl_pkg::ROW_W+1)'(trl_pkg::SCREEN_ROWS);

	// byte decode
	always_comb begin
		head_d   = head_q;
		cursor_d = cursor_q;
		esc_d    = esc_q;
		brk_d    = brk_q;
		clear_en = 1'b0;
		start_wr = 1'b0;
		start_rd = 1'b0;
		wl_d     = head_dec;
		wcol_d   = cursor_q[trl_pkg::COL_W-1:0];
		if (request.command == trl_pkg::CMD_READ) begin
			start_rd = row_ok;
		end else if (esc_q) begin
			if (!brk_q) begin
				if (b == trl_pkg::CH_LBRACK) begin
					brk_d = 1'b1;
				end
			end else if (is_letter) begin
				esc_d = 1'b0;
				brk_d = 1'b0;
			end
		end else if (b == trl_pkg::CH_ESC) begin
			esc_d = 1'b1;
			brk_d = 1'b0;
		end else if (b == trl_pkg::CH_LF) begin
			head_d   = head_inc;
			clear_en = 1'b1;
			cursor_d = '0;
		end else if (b == trl_pkg::CH_CR) begin
			cursor_d = '0;
		end else if (b == trl_pkg::CH_BS) begin
			if (cursor_q != '0) begin
				cursor_d = cursor_q - 1'b1;
			end
		end else if (b == trl_pkg::CH_TAB) begin
			if (tab_next < (trl_pkg::CUR_W+1)'(trl_pkg::LINE_COLUMNS)) begin
				cursor_d = trl_pkg::CUR_W'(tab_next);
			end
		end else if (is_print) begin
			start_wr = 1'b1;
			if (full) begin
				// wrap: old head becomes the line being written
				head_d   = head_inc;
				clear_en = 1'b1;
				wl_d     = head_q;
				wcol_d   = '0;
				cursor_d = trl_pkg::CUR_W'(1);
			end else begin
				cursor_d = cursor_q + 1'b1;
			end
		end
	end

	assign mem_re    = accept && (start_wr || start_rd);
	assign mem_raddr = start_rd ? rline : wl_d;

	// merge the new character into the fetched row
	always_comb begin
		mem_wdata = row_valid_q[wl_q] ? mem_rdata : trl_pkg::SPACE_ROW;
		mem_wdata[wcol_q*trl_pkg::CHAR_W +: trl_pkg::CHAR_W] = wchar_q;
	end
	assign mem_we    = (state_q == trl_pkg::ST_WRITE);
	assign mem_waddr = wl_q;

	always_comb begin
		load_row = row_valid_q[rline_q] ? mem_rdata : trl_pkg::SPACE_ROW;
		for (int k = 0; k < trl_pkg::LINE_COLUMNS; k++) begin
			load_mask[k] = load_row[k*trl_pkg::CHAR_W +: trl_pkg::CHAR_W] != trl_pkg::SPACE_CHAR;
		end
	end

	// a column is kept while any non-space lies at or after it
	assign keep      = |(mask_q >> rcol_q);
	assign slot_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trl_pkg::ST_IDLE;
			head_q      <= '0;
			cursor_q    <= '0;
			esc_q       <= 1'b0;
			brk_q       <= 1'b0;
			row_valid_q <= '0;
			rcol_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !(state_q == trl_pkg::ST_EMIT && slot_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				trl_pkg::ST_IDLE: begin
					if (accept) begin
						head_q   <= head_d;
						cursor_q <= cursor_d;
						esc_q    <= esc_d;
						brk_q    <= brk_d;
						if (clear_en) begin
							row_valid_q[head_inc] <= 1'b0;
						end
						if (start_wr) begin
							state_q <= trl_pkg::ST_WRITE;
						end else if (start_rd) begin
							state_q <= trl_pkg::ST_LOAD;
						end
					end
				end
				trl_pkg::ST_WRITE: begin
					row_valid_q[wl_q] <= 1'b1;
					state_q           <= trl_pkg::ST_IDLE;
				end
				trl_pkg::ST_LOAD: begin
					rcol_q  <= '0;
					state_q <= trl_pkg::ST_EMIT;
				end
				trl_pkg::ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						rcol_q      <= rcol_q + 1'b1;
						if (rcol_q == trl_pkg::LAST_COL) begin
							state_q <= trl_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= trl_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			wl_q    <= wl_d;
			wcol_q  <= wcol_d;
			wchar_q <= b[trl_pkg::CHAR_W-1:0];
			rline_q <= rline;
		end
		if (state_q == trl_pkg::ST_LOAD) begin
			row_q  <= load_row;
			mask_q <= load_mask;
		end
		if (state_q == trl_pkg::ST_EMIT && slot_free) begin
			out_char_q <= keep ?
				row_q[rcol_q*trl_pkg::CHAR_W +: trl_pkg::CHAR_W] : '0;
			out_col_q  <= rcol_q;
			out_last_q <= (rcol_q == trl_pkg::LAST_COL);
		end
	end

	assign request.ready    = (state_q == trl_pkg::ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.character = out_char_q;
	assign result.column    = out_col_q;
	assign result.last      = out_last_q;

	assign status.busy   = (state_q != trl_pkg::ST_IDLE);
	assign status.mem_we = mem_we;

endmodule

`default_nettype wire
